### sv/tcw_pkg.sv
// Shared constants, types and address helpers for the text console writer.
package tcw_pkg;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int RESERVED_ROWS = 1;

	localparam int HOME_ROW   = (RESERVED_ROWS < ROWS) ? RESERVED_ROWS : ROWS - 1;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int POS_W      = 11;

	localparam logic [ADDR_W-1:0] HOME_START = ADDR_W'(HOME_ROW * COLUMNS);
	localparam logic [ADDR_W-1:0] COPY_START = ADDR_W'((HOME_ROW + 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_START = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
	localparam logic              HAS_COPY   = (HOME_ROW + 1) < ROWS;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
	localparam logic [7:0]  CH_BACKSPACE = 8'h08;
	localparam logic [7:0]  CH_SPACE     = 8'h20;
	localparam logic [7:0]  RESET_ATTR   = 8'h0F;
	localparam logic [15:0] RESET_CELL   = {RESET_ATTR, CH_SPACE};

	typedef struct packed {
		logic       put_en;
		logic       clear_en;
		logic [7:0] ch;
	} tcw_ctl_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] nxt_pos;
		logic             scroll;
	} tcw_cur_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
	endfunction

	function automatic logic [POS_W-1:0] pos_of(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] a;
		a = cell_addr(row, col);
		return POS_W'(a);
	endfunction

endpackage

### sv/tcw_cursor.sv
// Cursor register and its update for put-char and clear commands.
module tcw_cursor (
	input  logic            clk,
	input  logic            arst_n,
	input  tcw_pkg::tcw_ctl_t ctl,
	output tcw_pkg::tcw_cur_t cur
);

	localparam logic [tcw_pkg::ROW_W-1:0] HOME = tcw_pkg::ROW_W'(tcw_pkg::HOME_ROW);
	localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

	logic [tcw_pkg::ROW_W-1:0] row_q, row_d;
	logic [tcw_pkg::COL_W-1:0] col_q, col_d;
	logic                      scroll;

	always_comb begin
		row_d  = row_q;
		col_d  = col_q;
		scroll = 1'b0;
		priority if (ctl.clear_en) begin
			row_d = HOME;
			col_d = '0;
		end else if (ctl.put_en) begin
			priority if (ctl.ch == tcw_pkg::CH_BACKSPACE) begin
				if (col_q != '0) begin
					col_d = col_q - tcw_pkg::COL_W'(1);
				end else if (row_q > HOME) begin
					row_d = row_q - tcw_pkg::ROW_W'(1);
					col_d = LAST_COL;
				end
			end else if (ctl.ch == tcw_pkg::CH_NEWLINE || col_q == LAST_COL) begin
				col_d = '0;
				if (row_q == LAST_ROW) begin
					scroll = 1'b1;
				end else begin
					row_d = row_q + tcw_pkg::ROW_W'(1);
				end
			end else begin
				col_d = col_q + tcw_pkg::COL_W'(1);
			end
		end else begin
			row_d = row_q;
			col_d = col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= HOME;
			col_q <= '0;
		end else begin
			row_q <= row_d;
			col_q <= col_d;
		end
	end

	assign cur.row     = row_q;
	assign cur.col     = col_q;
	assign cur.nxt_pos = tcw_pkg::pos_of(row_d, col_d);
	assign cur.scroll  = scroll;

	a_row_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		row_q >= HOME && row_q <= LAST_ROW && col_q <= LAST_COL)
		else $error("cursor outside text area");

	a_scroll_keeps_last: assert property (@(posedge clk) disable iff (!arst_n)
		scroll |=> row_q == LAST_ROW && col_q == '0)
		else $error("scroll did not leave cursor at start of last row");

endmodule

### sv/text_console_writer.sv
// Text console writer top level: screen memory, sweep sequencer and stream ports.
//
// A put-char, newline, backspace or direct cell write that does not scroll
// leaves the block idle, so one item per cycle is accepted while results are
// taken. A cell read waits in the done state for the registered read data of
// the screen memory. A newline or row wrap on the last row scrolls the text
// area through the single screen memory, one cell per cycle: the rows below
// HOME_ROW are copied up one row, then the last row is blanked with the text
// attribute. A clear blanks the rows from HOME_ROW to the last row. After reset
// the block runs a clearing pass over all ROWS*COLUMNS cells before it accepts
// its first item; configuration writes are taken at any time.
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,     // text_attr
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // char_code, cell_row, cell_col, cell_attr, zero pad
	input  logic [1:0]  s_tuser,      // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,      // cursor_pos, read_cell, zero pad
	output logic        m_tuser       // status
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_COPY  = 3'd2;
	localparam logic [2:0] S_BLANK = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                  state_q;
	logic [tcw_pkg::ADDR_W-1:0]  ptr_q;
	logic                        cp_wv_q;
	logic [tcw_pkg::ADDR_W-1:0]  cp_wa_q;
	logic [tcw_pkg::POS_W-1:0]   res_pos_q;
	logic                        res_st_q;
	logic                        res_rd_q;
	logic [7:0]                  text_attr_q;
	logic                        m_tvalid_q;

	logic [15:0]                 mem [tcw_pkg::CELL_COUNT];
	logic [15:0]                 mem_rd_q;
	logic                        mem_we, mem_re;
	logic [tcw_pkg::ADDR_W-1:0]  mem_wa, mem_ra;
	logic [15:0]                 mem_wd;

	logic [1:0]  cmd;
	logic [7:0]  char_code, cell_attr;
	logic [4:0]  cell_row;
	logic [6:0]  cell_col;
	logic        acc, in_range, out_free, printable, res_go;
	logic [tcw_pkg::ADDR_W-1:0] direct_addr, cursor_addr;

	tcw_pkg::tcw_ctl_t ctl;
	tcw_pkg::tcw_cur_t cur;

	assign cmd       = s_tuser;
	assign char_code = s_tdata[7:0];
	assign cell_row  = s_tdata[12:8];
	assign cell_col  = s_tdata[19:13];
	assign cell_attr = s_tdata[27:20];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign in_range    = (32'(cell_row) < tcw_pkg::ROWS) && (32'(cell_col) < tcw_pkg::COLUMNS);
	assign direct_addr = tcw_pkg::cell_addr(cell_row[tcw_pkg::ROW_W-1:0],
		cell_col[tcw_pkg::COL_W-1:0]);
	assign cursor_addr = tcw_pkg::cell_addr(cur.row, cur.col);
	assign printable   = (char_code != tcw_pkg::CH_NEWLINE) && (char_code != tcw_pkg::CH_BACKSPACE);

	assign ctl.put_en   = acc && (cmd == tcw_pkg::CMD_PUT);
	assign ctl.clear_en = acc && (cmd == tcw_pkg::CMD_CLEAR);
	assign ctl.ch       = char_code;

	assign res_go = out_free && ((acc && !(ctl.put_en && cur.scroll) && !ctl.clear_en
		&& cmd != tcw_pkg::CMD_READ) || state_q == S_DONE);

	tcw_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cur    (cur)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = tcw_pkg::RESET_CELL;
		mem_re = 1'b0;
		mem_ra = direct_addr;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (acc) begin
					priority if (cmd == tcw_pkg::CMD_PUT) begin
						mem_we = printable;
						mem_wa = cursor_addr;
						mem_wd = {text_attr_q, char_code};
					end else if (cmd == tcw_pkg::CMD_WRITE) begin
						mem_we = in_range;
						mem_wa = direct_addr;
						mem_wd = {cell_attr, char_code};
					end else if (cmd == tcw_pkg::CMD_READ) begin
						mem_re = in_range;
					end else begin
						mem_we = 1'b0;
					end
				end
			end
			S_COPY: begin
				mem_re = 1'b1;
				mem_ra = ptr_q;
				mem_we = cp_wv_q;
				mem_wa = cp_wa_q;
				mem_wd = mem_rd_q;
			end
			S_BLANK: begin
				mem_we = 1'b1;
				if (cp_wv_q) begin
					mem_wa = cp_wa_q;
					mem_wd = mem_rd_q;
				end else begin
					mem_wd = {text_attr_q, tcw_pkg::CH_SPACE};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= tcw_pkg::RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			text_attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			ptr_q      <= '0;
			cp_wv_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cp_wv_q <= (state_q == S_COPY);
			if (res_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
					if (ptr_q == tcw_pkg::LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						priority if (ctl.put_en && cur.scroll) begin
							state_q <= tcw_pkg::HAS_COPY ? S_COPY : S_BLANK;
							ptr_q   <= tcw_pkg::HAS_COPY ? tcw_pkg::COPY_START
								: tcw_pkg::LAST_START;
						end else if (ctl.clear_en) begin
							state_q <= S_BLANK;
							ptr_q   <= tcw_pkg::HOME_START;
						end else if (cmd == tcw_pkg::CMD_READ || !out_free) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_COPY: begin
					ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
					if (ptr_q == tcw_pkg::LAST_ADDR) begin
						state_q <= S_BLANK;
						ptr_q   <= tcw_pkg::LAST_START;
					end
				end
				S_BLANK: begin
					if (!cp_wv_q) begin
						ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
						if (ptr_q == tcw_pkg::LAST_ADDR) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COPY) begin
			cp_wa_q <= ptr_q - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
		end
		if (acc) begin
			res_pos_q <= cur.nxt_pos;
			res_st_q  <= (cmd == tcw_pkg::CMD_WRITE || cmd == tcw_pkg::CMD_READ) && !in_range;
			res_rd_q  <= (cmd == tcw_pkg::CMD_READ) && in_range;
		end
		if (acc && out_free) begin
			m_tdata <= {5'd0, 16'd0, cur.nxt_pos};
			m_tuser <= (cmd == tcw_pkg::CMD_WRITE) && !in_range;
		end else if (state_q == S_DONE && out_free) begin
			m_tdata <= {5'd0, res_rd_q ? mem_rd_q : 16'd0, res_pos_q};
			m_tuser <= res_st_q;
		end
	end

	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == tcw_pkg::CMD_READ |=> state_q == S_DONE)
		else $error("read item did not wait for memory data");

	a_copy_behind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COPY && cp_wv_q |-> cp_wa_q < ptr_q)
		else $error("scroll write overtook its read");

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> !m_tvalid_q)
		else $error("item delivered during clearing pass");

	a_blank_after_copy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COPY && ptr_q == tcw_pkg::LAST_ADDR |=>
		state_q == S_BLANK && ptr_q == tcw_pkg::LAST_START && cp_wv_q)
		else $error("scroll did not move on to blanking the last row");

endmodule

### dv/testbench.sv
// Self-checking stream testbench for the text console writer.
`timescale 1ns / 100ps

module testbench;
	import tcw_pkg::*;

	localparam logic [10:0] HOME_POS = 11'(HOME_ROW * COLUMNS);
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [10:0] pos;
		logic [15:0] cell_word;
		logic        status;
	} console_report_t;

	typedef struct packed {
		logic            typed;
		console_report_t rep;
	} preset_report_t;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  ch;
		logic [4:0]  row;
		logic [6:0]  col;
		logic [7:0]  attr;
		int          reps;
		logic        typed;
		logic [10:0] pos;
		logic [15:0] cell_word;
		logic        bad;
	} console_step_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	logic [15:0] screen [CELL_COUNT];
	int          cur_row;
	int          cur_col;
	logic [7:0]  attr_now;
	bit          steady;

	console_report_t owed_reports [$];
	preset_report_t  preset_reports [$];

	int n_errors;
	int n_items;
	int n_scrolls;
	int n_clears;
	int n_reads;
	int n_bad;
	int n_attr_writes;

	console_step_t opening [26] = '{
		'{CMD_READ,  8'h00,        5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS, RESET_CELL, 1'b0},
		'{CMD_READ,  8'h00,        5'(ROWS-1),  7'(COLUMNS-1), 8'h00, 1, 1'b1,
			HOME_POS, RESET_CELL, 1'b0},
		'{CMD_READ,  8'h00,        5'(ROWS),    7'd0,          8'h00, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b1},
		'{CMD_READ,  8'h00,        5'd0,        7'(COLUMNS),   8'h00, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b1},
		'{CMD_READ,  8'hFF,        5'd31,       7'd127,        8'hFF, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b1},
		'{CMD_WRITE, 8'hFF,        5'd31,       7'd127,        8'hFF, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b1},
		'{CMD_WRITE, 8'h41,        5'd0,        7'd0,          8'h70, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS, 16'h7041, 1'b0},
		'{CMD_WRITE, CH_NEWLINE,   5'(ROWS-1),  7'(COLUMNS-1), 8'hFF, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'(ROWS-1),  7'(COLUMNS-1), 8'h00, 1, 1'b1,
			HOME_POS, 16'hFF0A, 1'b0},
		'{CMD_PUT,   CH_BACKSPACE, 5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b0},
		'{CMD_PUT,   8'h00,        5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS + 11'd1, 16'h0000, 1'b0},
		'{CMD_PUT,   8'hFF,        5'd31,       7'd127,        8'hFF, 1, 1'b1,
			HOME_POS + 11'd2, 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'(HOME_ROW), 7'd0,         8'h00, 1, 1'b1,
			HOME_POS + 11'd2, {RESET_ATTR, 8'h00}, 1'b0},
		'{CMD_PUT,   CH_BACKSPACE, 5'd31,       7'd127,        8'hFF, 1, 1'b1,
			HOME_POS + 11'd1, 16'h0000, 1'b0},
		'{CMD_PUT,   CH_NEWLINE,   5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS + 11'(COLUMNS), 16'h0000, 1'b0},
		'{CMD_PUT,   CH_BACKSPACE, 5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS + 11'(COLUMNS - 1), 16'h0000, 1'b0},
		'{CMD_PUT,   8'h5A,        5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS + 11'(COLUMNS), 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'(HOME_ROW), 7'(COLUMNS-1), 8'h00, 1, 1'b1,
			HOME_POS + 11'(COLUMNS), {RESET_ATTR, 8'h5A}, 1'b0},
		'{CMD_CLEAR, 8'hFF,        5'd31,       7'd127,        8'hFF, 1, 1'b1,
			HOME_POS, 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'(HOME_ROW), 7'd1,         8'h00, 1, 1'b1,
			HOME_POS, RESET_CELL, 1'b0},
		'{CMD_READ,  8'h00,        5'd0,        7'd0,          8'h00, 1, 1'b1,
			HOME_POS, 16'h7041, 1'b0},
		'{CMD_WRITE, 8'h77,        5'(ROWS-1),  7'd0,          8'h3C, 1, 1'b0,
			11'd0, 16'h0000, 1'b0},
		'{CMD_PUT,   CH_NEWLINE,   5'd0,        7'd0,          8'h00, ROWS, 1'b0,
			11'd0, 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'(ROWS-2),  7'd0,          8'h00, 1, 1'b0,
			11'd0, 16'h0000, 1'b0},
		'{CMD_READ,  8'h00,        5'(ROWS-1),  7'd0,          8'h00, 1, 1'b0,
			11'd0, 16'h0000, 1'b0}
	};

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void blank_line(input int y);
		for (int x = 0; x < COLUMNS; x++)
			screen[y * COLUMNS + x] = {attr_now, CH_SPACE};
	endfunction

	function automatic void step_down();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			for (int y = HOME_ROW + 1; y < ROWS; y++)
				for (int x = 0; x < COLUMNS; x++)
					screen[(y - 1) * COLUMNS + x] = screen[y * COLUMNS + x];
			blank_line(ROWS - 1);
			cur_row = ROWS - 1;
			n_scrolls++;
		end
	endfunction

	function automatic console_report_t apply_console_cmd(input logic [1:0] op,
			input logic [7:0] ch, input logic [4:0] r, input logic [6:0] c,
			input logic [7:0] a);
		console_report_t rep;
		bit hit;
		int idx;
		rep = '0;
		hit = (int'(r) < ROWS) && (int'(c) < COLUMNS);
		idx = int'(r) * COLUMNS + int'(c);
		case (op)
			CMD_PUT: begin
				if (ch == CH_NEWLINE) begin
					step_down();
				end else if (ch == CH_BACKSPACE) begin
					if (cur_col > 0) begin
						cur_col--;
					end else if (cur_row > HOME_ROW) begin
						cur_row--;
						cur_col = COLUMNS - 1;
					end
				end else begin
					screen[cur_row * COLUMNS + cur_col] = {attr_now, ch};
					cur_col++;
					if (cur_col >= COLUMNS)
						step_down();
				end
			end
			CMD_CLEAR: begin
				for (int y = HOME_ROW; y < ROWS; y++)
					blank_line(y);
				cur_row = HOME_ROW;
				cur_col = 0;
				n_clears++;
			end
			CMD_WRITE: begin
				if (hit)
					screen[idx] = {a, ch};
				else
					rep.status = 1'b1;
			end
			default: begin
				n_reads++;
				if (hit)
					rep.cell_word = screen[idx];
				else
					rep.status = 1'b1;
			end
		endcase
		if (!hit && (op == CMD_WRITE || op == CMD_READ))
			n_bad++;
		rep.pos = 11'(cur_row * COLUMNS + cur_col);
		return rep;
	endfunction

	task automatic flag_mismatch(input string what, input console_report_t want,
			input console_report_t got);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t: %s: pos %0d/%0d cell %h/%h status %b/%b (expected/actual)",
				$realtime, what, want.pos, got.pos, want.cell_word, got.cell_word,
				want.status, got.status);
	endtask

	always @(posedge clk) begin : port_watch
		console_report_t want;
		console_report_t got;
		preset_report_t  preset;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				attr_now = cfg_data;
				n_attr_writes++;
			end
			if (s_tvalid && s_tready) begin
				want = apply_console_cmd(s_tuser, s_tdata[7:0], s_tdata[12:8],
					s_tdata[19:13], s_tdata[27:20]);
				preset = preset_reports.pop_front();
				if (preset.typed)
					want = preset.rep;
				owed_reports.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.pos = m_tdata[10:0];
				got.cell_word = m_tdata[26:11];
				got.status = m_tuser;
				if (owed_reports.size() == 0) begin
					flag_mismatch("result with nothing pending", '0, got);
				end else begin
					want = owed_reports.pop_front();
					if (got.pos !== want.pos || got.cell_word !== want.cell_word ||
							got.status !== want.status)
						flag_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch,
			input logic [4:0] r, input logic [6:0] c, input logic [7:0] a,
			input logic typed = 1'b0, input console_report_t rep = '0);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		preset_reports.push_back({typed, rep});
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'h0, a, c, r, ch};
		do @(posedge clk); while (!s_tready);
		n_items++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_attr(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int pick;
		int len;
		int k;
		int first;
		logic [7:0] ch;
		logic [4:0] r;
		logic [6:0] c;
		console_report_t rep;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		s_tvalid = 1'b0;
		s_tdata = 32'h0;
		s_tuser = CMD_PUT;
		steady = 1'b0;
		for (int i = 0; i < CELL_COUNT; i++)
			screen[i] = RESET_CELL;
		cur_row = HOME_ROW;
		cur_col = 0;
		attr_now = RESET_ATTR;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			rep = {opening[i].pos, opening[i].cell_word, opening[i].bad};
			repeat (opening[i].reps)
				send_cmd(opening[i].op, opening[i].ch, opening[i].row, opening[i].col,
					opening[i].attr, opening[i].typed, rep);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_attr(p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom));
			first = n_items;
			while (n_items - first < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				steady = ($urandom_range(0, 4) == 0);
				if (pick < 40) begin
					len = $urandom_range(1, 24);
					repeat (len) begin
						k = $urandom_range(0, 19);
						ch = (k == 0) ? CH_NEWLINE :
							(k < 3) ? 8'($urandom) : 8'($urandom_range(8'h21, 8'h7E));
						send_cmd(CMD_PUT, ch, 5'($urandom), 7'($urandom), 8'($urandom));
					end
					if ($urandom_range(0, 1) == 1)
						send_cmd(CMD_READ, 8'($urandom), 5'(cur_row),
							7'($urandom_range(0, COLUMNS - 1)), 8'($urandom));
				end else if (pick < 50) begin
					len = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 30) :
						$urandom_range(1, 4);
					repeat (len)
						send_cmd(CMD_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom),
							8'($urandom));
				end else if (pick < 60) begin
					len = $urandom_range(1, 12);
					repeat (len) begin
						ch = ($urandom_range(0, 3) != 0) ? CH_BACKSPACE :
							8'($urandom_range(8'h21, 8'h7E));
						send_cmd(CMD_PUT, ch, 5'($urandom), 7'($urandom), 8'($urandom));
					end
				end else if (pick < 80) begin
					r = 5'($urandom_range(0, ROWS - 1));
					c = 7'($urandom_range(0, COLUMNS - 1));
					send_cmd(CMD_WRITE, 8'($urandom), r, c, 8'($urandom));
					if ($urandom_range(0, 2) != 0)
						send_cmd(CMD_READ, 8'($urandom), r, c, 8'($urandom));
					send_cmd(CMD_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
						7'($urandom_range(0, COLUMNS - 1)), 8'($urandom));
				end else if (pick < 83) begin
					send_cmd(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom),
						8'($urandom));
				end else begin
					len = $urandom_range(1, 3);
					repeat (len)
						send_cmd(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom),
							8'($urandom));
				end
			end
		end

		steady = 1'b0;
		drain();
		repeat (2000) @(posedge clk);

		$display("%0d commands under %0d attribute settings: %0d scrolls, %0d clears,",
			n_items, n_attr_writes + 1, n_scrolls, n_clears);
		$display("%0d cell reads, %0d out-of-range cell addresses", n_reads, n_bad);
		if (n_errors == 0 && owed_reports.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### files.f
sv/tcw_pkg.sv
sv/tcw_cursor.sv
sv/text_console_writer.sv
dv/testbench.sv
